[rtl/core/bso_pkg.sv]
package bso_pkg;

   // Q30 value of pi/2
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // working fraction of the impulse train and sum
   localparam int WORK_FRAC = 44;

   // divider: 63-bit product with 12 fraction bits appended
   localparam int DQ_W  = 75;
   localparam int CNT_W = 7;

   // leak: mag*199/200 rounded equals mag - floor((mag+99)/200);
   // x/200 is (x>>3)/25, and ceil(2^34/25) is exact for x>>3 below 2^29
   localparam logic [48:0] DECAY_BIAS  = 49'd99;
   localparam logic [31:0] DECAY_RECIP = 32'd687194768;
   localparam int          DECAY_SHIFT = 34;

   typedef enum logic [1:0] {
      REG_PERIOD    = 2'd0,
      REG_INV_PER   = 2'd1,
      REG_HARMONICS = 2'd2,
      REG_UNUSED    = 2'd3
   } reg_index_type;

   localparam logic [31:0] PERIOD_RESET  = 32'd6553600;
   localparam logic [31:0] INV_PER_RESET = 32'd42949673;

endpackage

[rtl/core/blit_sawtooth_oscillator.sv]
// Band-limited sawtooth oscillator. Each accepted word with advance set yields one Q4.28
// sample on rsp; a word with advance clear is taken and changes nothing. A new word is
// accepted only once the sample is finished and the previous sample is taken. The
// impulse-train quotient comes from a one-bit-per-cycle restoring divider of 75 steps,
// skipped when the phase or the denominator sine is zero, with the sines read one point a cycle
// from a quarter-wave table and interpolated on the one shared multiplier, which also
// does the 0.995 leak as two reciprocal multiplications. period (Q16.16) and
// inverse_period (Q0.32) are both supplied by software and used as given.
module blit_sawtooth_oscillator
   import bso_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] advance
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [31:0] sample
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TABLE_SIZE = (1 << SINE_TABLE_BITS) + 2;
   localparam int IDX_W      = SINE_TABLE_BITS + 1;
   localparam int FRAC_W     = 31 - SINE_TABLE_BITS;
   localparam int SH         = 48 - SAMPLE_WIDTH;
   localparam int SH_DN      = (SAMPLE_WIDTH >= 32) ? SAMPLE_WIDTH - 32 : 0;
   localparam int SH_UP      = (SAMPLE_WIDTH >= 32) ? 0 : 32 - SAMPLE_WIDTH;
   localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

   typedef logic [30:0] sine_tab_type [TABLE_SIZE];

   // shift-and-subtract quotient, used only while building the table
   function automatic longint unsigned div_small(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic sine_tab_type build_tab();
      sine_tab_type     tab;
      longint unsigned  theta;
      longint unsigned  theta2;
      longint unsigned  term;
      longint unsigned  dv;
      longint           sum;
      for (int i = 0; i <= (1 << SINE_TABLE_BITS); i++) begin
         theta  = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
         theta2 = (theta * theta) >> 30;
         term   = theta;
         sum    = longint'(theta);
         for (int k = 1; k <= 7; k++) begin
            case (k)
               1: dv = 6;
               2: dv = 20;
               3: dv = 42;
               4: dv = 72;
               5: dv = 110;
               6: dv = 156;
               default: dv = 210;
            endcase
            term = div_small((term * theta2) >> 30, dv);
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > 64'sd1073741824) sum = 64'sd1073741824;
         tab[i] = 31'(sum);
      end
      tab[TABLE_SIZE-1] = tab[TABLE_SIZE-2];
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_tab();

   typedef enum logic [4:0] {
      S_IDLE, S_MA, S_MA_GET, S_SIN_ADDR, S_SIN_LO, S_SIN_HI, S_SIN_MUL, S_SIN_GET,
      S_MPH, S_MPH_GET, S_BIG, S_BIG_GET, S_DIV, S_BLIT, S_SUM,
      S_DEC_HI, S_DEC_HI_GET, S_DEC_LO, S_DEC_LO_GET, S_DONE
   } state_type;

   state_type                 state_ff;
   logic [31:0]               period_ff;
   logic [31:0]               inv_per_ff;
   logic [14:0]               harm_ff;
   logic [31:0]               phase_ff;
   logic signed [SAMPLE_WIDTH-1:0] integ_ff;
   logic [63:0]               prod_ff;
   logic [47:0]               a32_ff;
   logic [32:0]               angle_ff;
   logic                      sine_sel_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [FRAC_W-1:0]         frac_ff;
   logic                      neg_ff;
   logic [30:0]               rom_ff;
   logic [30:0]               lo_ff;
   logic                      pos_ff;
   logic [30:0]               s_ff;
   logic [30:0]               nmag_ff;
   logic                      num_neg_ff;
   logic [DQ_W-1:0]           dq_ff;
   logic [30:0]               rem_ff;
   logic [30:0]               div_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic signed [63:0]        blit_ff;
   logic signed [SAMPLE_WIDTH-1:0] satf_ff;
   logic [24:0]               dec_qh_ff;
   logic [31:0]               dec_t_ff;
   logic [SAMPLE_WIDTH-1:0]   dec_q_ff;
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_data_ff;

   // harmonic count, always odd
   logic [15:0] m;
   assign m = (harm_ff == 15'd0) ? {period_ff[31:17], 1'b1} : {harm_ff, 1'b1};

   // leak operands, from the saturated sum
   logic [SAMPLE_WIDTH-1:0] sat_mag;
   logic [48:0]             dec_y;
   assign sat_mag = satf_ff[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-satf_ff) : SAMPLE_WIDTH'(satf_ff);
   assign dec_y   = 49'(sat_mag) + DECAY_BIAS;

   // shared multiplier operands
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   always_comb begin
      mul_a = 32'd0;
      mul_b = 32'd0;
      unique case (state_ff)
         S_MA: begin
            mul_a = {16'd0, m};
            mul_b = inv_per_ff;
         end
         S_MPH: begin
            mul_a = {16'd0, m};
            mul_b = phase_ff;
         end
         S_SIN_MUL: begin
            mul_a = {1'b0, rom_ff - lo_ff};
            mul_b = 32'(frac_ff);
         end
         S_BIG: begin
            mul_a = {1'b0, nmag_ff};
            mul_b = inv_per_ff;
         end
         S_DEC_HI: begin
            mul_a = {10'd0, dec_y[48:27]};
            mul_b = DECAY_RECIP;
         end
         S_DEC_LO: begin
            mul_a = {3'd0, dec_t_ff[31:3]};
            mul_b = DECAY_RECIP;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   // fold the half wave onto the quarter table
   logic [31:0] fold;
   assign fold = angle_ff[31] ? (~angle_ff[31:0] + 32'd1) : angle_ff[31:0];

   logic [IDX_W-1:0] rom_addr;
   assign rom_addr = (state_ff == S_SIN_HI) ? idx_ff + IDX_W'(1) : idx_ff;

   logic [30:0] sine_v;
   assign sine_v = lo_ff + (pos_ff ? 31'(prod_ff >> FRAC_W) : 31'd0);

   // restoring divider step
   logic [31:0] trial;
   logic        q_bit;
   logic [30:0] rem_in;
   assign trial  = {rem_ff, dq_ff[DQ_W-1]};
   assign q_bit  = (trial >= {1'b0, div_ff});
   assign rem_in = q_bit ? 31'(trial - {1'b0, div_ff}) : trial[30:0];

   logic [59:0] a44;
   assign a44 = {a32_ff, 12'd0};

   logic [59:0] qmag;
   assign qmag = (dq_ff >= DQ_W'(a44)) ? a44 : dq_ff[59:0];

   // sum of impulse train, mean and leaky state
   logic signed [63:0] integ_ext;
   logic signed [63:0] sum;
   logic signed [63:0] sum_sh;
   assign integ_ext = 64'(integ_ff);
   assign sum    = blit_ff - $signed({20'd0, inv_per_ff, 12'd0}) + (integ_ext <<< SH);
   assign sum_sh = sum >>> SH;

   // upper 25 bits divided first, remainder carried into the lower 24
   logic [24:0] dec_qh;
   logic [24:0] dec_rh;
   logic [48:0] dec_quo;
   assign dec_qh  = prod_ff[DECAY_SHIFT+24:DECAY_SHIFT];
   // times 200 = 128 + 64 + 8
   assign dec_rh  = dec_y[48:24] - ((dec_qh << 7) + (dec_qh << 6) + (dec_qh << 3));
   assign dec_quo = {dec_qh_ff, prod_ff[DECAY_SHIFT+23:DECAY_SHIFT]};

   logic signed [63:0] q28_wide;
   assign q28_wide = (64'(satf_ff) >>> SH_DN) <<< SH_UP;

   logic csr_wr;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
      rom_ff  <= SINE_TAB[rom_addr];
      if (reset) begin
         state_ff     <= S_IDLE;
         period_ff    <= PERIOD_RESET;
         inv_per_ff   <= INV_PER_RESET;
         harm_ff      <= 15'd0;
         phase_ff     <= 32'd0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            unique case (reg_index_type'(csr_paddr[3:2]))
               REG_PERIOD:    period_ff  <= csr_pwdata;
               REG_INV_PER:   inv_per_ff <= csr_pwdata;
               REG_HARMONICS: harm_ff    <= csr_pwdata[14:0];
               default: ;
            endcase
         end
         // in S_DONE a taken word is always replaced below
         if (rsp_tready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tdata[0]) state_ff <= S_MA;
            end
            S_MA: state_ff <= S_MA_GET;
            S_MA_GET: begin
               a32_ff      <= prod_ff[47:0];
               angle_ff    <= {1'b0, phase_ff};
               sine_sel_ff <= 1'b0;
               state_ff    <= S_SIN_ADDR;
            end
            S_SIN_ADDR: begin
               idx_ff   <= fold[31:31-SINE_TABLE_BITS];
               frac_ff  <= fold[FRAC_W-1:0];
               neg_ff   <= angle_ff[32];
               state_ff <= S_SIN_LO;
            end
            S_SIN_LO: state_ff <= S_SIN_HI;
            S_SIN_HI: begin
               lo_ff    <= rom_ff;
               state_ff <= S_SIN_MUL;
            end
            S_SIN_MUL: begin
               pos_ff   <= rom_ff > lo_ff;
               state_ff <= S_SIN_GET;
            end
            S_SIN_GET: begin
               if (!sine_sel_ff) begin
                  s_ff     <= sine_v;
                  state_ff <= S_MPH;
               end else begin
                  nmag_ff    <= sine_v;
                  num_neg_ff <= neg_ff && (sine_v != 31'd0);
                  if (phase_ff == 32'd0 || s_ff == 31'd0) begin
                     // zero denominator sine: take the limit m/p
                     blit_ff  <= $signed({4'd0, a44});
                     state_ff <= S_SUM;
                  end else begin
                     state_ff <= S_BIG;
                  end
               end
            end
            S_MPH: state_ff <= S_MPH_GET;
            S_MPH_GET: begin
               angle_ff    <= prod_ff[32:0];
               sine_sel_ff <= 1'b1;
               state_ff    <= S_SIN_ADDR;
            end
            S_BIG: state_ff <= S_BIG_GET;
            S_BIG_GET: begin
               dq_ff    <= {prod_ff[62:0], 12'd0};
               rem_ff   <= 31'd0;
               div_ff   <= s_ff;
               cnt_ff   <= CNT_W'(DQ_W);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               dq_ff  <= {dq_ff[DQ_W-2:0], q_bit};
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - CNT_W'(1);
               if (cnt_ff == CNT_W'(1)) state_ff <= S_BLIT;
            end
            S_BLIT: begin
               blit_ff  <= num_neg_ff ? -$signed({4'd0, qmag}) : $signed({4'd0, qmag});
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (sum_sh > SAT_MAX) satf_ff <= SAMPLE_WIDTH'(SAT_MAX);
               else if (sum_sh < SAT_MIN) satf_ff <= SAMPLE_WIDTH'(SAT_MIN);
               else satf_ff <= SAMPLE_WIDTH'(sum_sh);
               state_ff <= S_DEC_HI;
            end
            S_DEC_HI: state_ff <= S_DEC_HI_GET;
            S_DEC_HI_GET: begin
               dec_qh_ff <= dec_qh;
               dec_t_ff  <= {dec_rh[7:0], dec_y[23:0]};
               state_ff  <= S_DEC_LO;
            end
            S_DEC_LO: state_ff <= S_DEC_LO_GET;
            S_DEC_LO_GET: begin
               dec_q_ff <= sat_mag - SAMPLE_WIDTH'(dec_quo);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  integ_ff     <= satf_ff[SAMPLE_WIDTH-1] ? -$signed(dec_q_ff)
                                                          : $signed(dec_q_ff);
                  phase_ff     <= phase_ff + inv_per_ff;
                  rsp_data_ff  <= q28_wide[31:0];
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_PERIOD:    csr_prdata = period_ff;
         REG_INV_PER:   csr_prdata = inv_per_ff;
         REG_HARMONICS: csr_prdata = {17'd0, harm_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_busy_after_tick: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[0] |=> !req_tready)
      else $error("ready held after a tick word");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff != CNT_W'(0))
      else $error("divider running with zero count");

   a_table_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SIN_LO |-> idx_ff <= IDX_W'(1 << SINE_TABLE_BITS))
      else $error("sine index past quarter wave");

   a_done_fills_output: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE && (!rsp_valid_ff || rsp_tready) |=> rsp_tvalid)
      else $error("finished sample not presented");

endmodule

[test/blit_sawtooth_oscillator_tb.sv]
module blit_sawtooth_oscillator_tb
   import bso_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_BITS = 10;
   localparam int TABLE_LEN  = (1 << TABLE_BITS) + 2;
   localparam int SETTLE     = 200;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [0] advance
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [31:0] sample
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = 4'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   blit_sawtooth_oscillator u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   longint signed sine_lut [TABLE_LEN];
   logic [31:0]   model_period;
   logic [31:0]   model_inv_period;
   logic [14:0]   model_harmonics;
   logic [31:0]   model_phase;
   longint signed model_leak;

   logic [7:0]  words_to_send [$];
   logic [31:0] samples_due [$];
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          errors = 0;
   bit          req_took = 1'b0;

   function automatic void build_sine_lut();
      logic [63:0]   theta, theta2, term;
      longint signed acc;
      for (int i = 0; i <= (1 << TABLE_BITS); i++) begin
         theta  = (64'(i) * HALF_PI_Q30) >> TABLE_BITS;
         theta2 = (theta * theta) >> 30;
         term   = theta;
         acc    = longint'(theta);
         for (int k = 1; k <= 7; k++) begin
            term = ((term * theta2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k & 1) acc -= longint'(term);
            else acc += longint'(term);
         end
         if (acc < 0) acc = 0;
         if (acc > 64'sd1073741824) acc = 64'sd1073741824;
         sine_lut[i] = acc;
      end
      sine_lut[(1 << TABLE_BITS) + 1] = sine_lut[1 << TABLE_BITS];
   endfunction

   // angle in units of pi/2^32, Q30 result
   function automatic longint signed sine_of(logic [63:0] angle);
      logic [63:0]   h, f, idx, frac;
      longint signed lo, hi, v;
      h = {32'd0, angle[31:0]};
      f = (h >= 64'h8000_0000) ? (64'h1_0000_0000 - h) : h;
      idx  = f >> (31 - TABLE_BITS);
      frac = f & ((64'd1 << (31 - TABLE_BITS)) - 1);
      if (idx > (1 << TABLE_BITS)) idx = 1 << TABLE_BITS;
      lo = sine_lut[idx];
      hi = sine_lut[idx + 1];
      v  = lo;
      if (hi > lo) v += longint'((64'(hi - lo) * frac) >> (31 - TABLE_BITS));
      return angle[32] ? -v : v;
   endfunction

   function automatic logic [31:0] next_sample();
      logic [63:0]   m, a32, a44, ip, nmag, big, q, r, mag;
      longint signed s, num, blit, acc, satf;
      ip = {32'd0, model_inv_period};
      if (model_harmonics == 0) m = 2 * 64'(model_period >> 17) + 1;
      else m = 2 * 64'(model_harmonics) + 1;
      a32 = m * ip;
      a44 = a32 << 12;
      blit = longint'(a44);
      if (model_phase != 0) begin
         s   = sine_of({32'd0, model_phase});
         num = sine_of(m * {32'd0, model_phase});
         if (s > 0) begin
            nmag = 64'(num < 0 ? -num : num);
            big  = nmag * ip;
            q    = big / 64'(s);
            r    = big % 64'(s);
            if (q >= a32) mag = a44;
            else mag = (q << 12) + ((r << 12) / 64'(s));
            blit = (num < 0) ? -longint'(mag) : longint'(mag);
         end
      end
      acc  = blit - longint'(ip << 12) + (model_leak <<< 16);
      satf = acc >>> 16;
      if (satf > 64'sd2147483647) satf = 64'sd2147483647;
      if (satf < -64'sd2147483648) satf = -64'sd2147483648;
      mag = 64'(satf < 0 ? -satf : satf);
      mag = (mag * 199 + 100) / 200;
      model_leak  = (satf < 0) ? -longint'(mag) : longint'(mag);
      model_phase = model_phase + model_inv_period;
      return satf[31:0];
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_took) begin
         if (words_to_send.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
            req_tdata  <= words_to_send.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      logic [31:0] want;
      req_took = req_tvalid && req_tready && !reset;
      if (req_took && req_tdata[0]) samples_due.push_back(next_sample());
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (samples_due.size() == 0) begin
            $display("%0t: unexpected sample, expected none, actual %h", $realtime, rsp_tdata);
            errors++;
         end else begin
            want = samples_due.pop_front();
            if (want !== rsp_tdata) begin
               $display("%0t: sample mismatch, expected %h, actual %h",
                        $realtime, want, rsp_tdata);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_PERIOD:    model_period = value;
         REG_INV_PER:   model_inv_period = value;
         REG_HARMONICS: model_harmonics = value[14:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (words_to_send.size() != 0 || req_tvalid || samples_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic setup(logic [31:0] per, logic [31:0] inv, logic [31:0] harm);
      csr_write(REG_PERIOD, per);
      csr_write(REG_INV_PER, inv);
      csr_write(REG_HARMONICS, harm);
   endtask

   initial begin
      logic [31:0] per;
      build_sine_lut();
      model_period     = PERIOD_RESET;
      model_inv_period = INV_PER_RESET;
      model_harmonics  = '0;
      model_phase      = '0;
      model_leak       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, no-tick words, run through the sine peak and beyond
      words_to_send.push_back(8'd0);
      words_to_send.push_back(8'd1);
      words_to_send.push_back(8'd0);
      repeat (8) words_to_send.push_back(8'd1);
      drain();
      setup(32'd131072, 32'h8000_0000, 32'd0);      // p = 2, wraps every other tick
      repeat (6) words_to_send.push_back(8'd1);
      drain();
      setup(32'hFFFF_FFFF, 32'd1, 32'hFFFF_8000);   // largest m, masked harmonics
      repeat (4) words_to_send.push_back(8'd1);
      drain();
      setup(32'd6553600, 32'h8000_0000, 32'h7FFF);  // inconsistent, saturates
      repeat (6) words_to_send.push_back(8'd1);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 79; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 79; end
            default: begin idle_pct = 21; stall_pct = 21; end
         endcase
         case (ph)
            0: setup(PERIOD_RESET, INV_PER_RESET, 32'd0);
            1: setup(32'd131072, 32'h8000_0000, 32'd0);
            2: setup(32'hFFFF_FFFF, 32'd1, 32'd0);
            3: setup(32'd6553600, 32'h8000_0000, 32'd32767);
            4: begin
               per = $urandom_range(32'd131072, 32'd16777216);
               setup(per, 32'((64'd1 << 48) / per), $urandom_range(0, 20));
            end
            default: setup($urandom, $urandom, $urandom);
         endcase
         repeat (90) words_to_send.push_back(($urandom_range(0, 99) < 88) ? 8'd1 : 8'd0);
         drain();
      end

      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
